/* rtl/grid_distance_map_defines.svh */
// Assertion helpers used by grid_distance_map.sv
`ifndef GRID_DISTANCE_MAP_DEFINES_SVH
`define GRID_DISTANCE_MAP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define GDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define GDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gdm_pkg.sv */
package gdm_pkg;

  // Item codes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_RUN    = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Register indexes on the APB port
  localparam logic [1:0] REG_ROWS_USED = 2'd0;
  localparam logic [1:0] REG_COLS_USED = 2'd1;
  localparam logic [1:0] REG_TUNNELING = 2'd2;

  localparam int DIST_W = 20;
  localparam int HARD_W = 8;
  // width of grid coordinates and limits during neighbor checks
  localparam int LIM_W  = 9;

  localparam logic [DIST_W-1:0] DIST_NONE = 20'hFFFFF;
  localparam logic [DIST_W-1:0] DIST_TOP  = 20'hFFFFE;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLEAR = 8'b0000_0010,
    ST_SEED  = 8'b0000_0100,
    ST_POP   = 8'b0000_1000,
    ST_CUR   = 8'b0001_0000,
    ST_CALC  = 8'b0010_0000,
    ST_NRD   = 8'b0100_0000,
    ST_NCHK  = 8'b1000_0000
  } state_t;

  // Cost of leaving a cell in the weighted search
  function automatic logic [HARD_W-1:0] leave_cost(input logic [HARD_W-1:0] h);
    logic [HARD_W-1:0] c;
    if (h <= 8'd84)       c = 8'd1;
    else if (h <= 8'd170) c = 8'd2;
    else if (h <= 8'd254) c = 8'd3;
    else                  c = 8'd255;
    return c;
  endfunction

  // Row offset of neighbor k, two's complement
  function automatic logic [LIM_W-1:0] nb_dy(input logic [2:0] k);
    logic [LIM_W-1:0] d;
    case (k)
      3'd0, 3'd1, 3'd2: d = '1;
      3'd3, 3'd4:       d = '0;
      default:          d = LIM_W'(1);
    endcase
    return d;
  endfunction

  // Column offset of neighbor k, two's complement
  function automatic logic [LIM_W-1:0] nb_dx(input logic [2:0] k);
    logic [LIM_W-1:0] d;
    case (k)
      3'd0, 3'd3, 3'd5: d = '1;
      3'd1, 3'd6:       d = '0;
      default:          d = LIM_W'(1);
    endcase
    return d;
  endfunction

endpackage

/* rtl/grid_distance_map.sv */
// Grid distance map. Load items (write one cell's hardness) and query items
// (read one cell's distance) are taken whenever the map is idle and may follow
// back to back; a query's result appears with out_valid in the cycle after its
// transfer and must be taken then. A run item holds busy high while it clears
// the distance memory, one cell per cycle, then seeds the source if it lies in
// the used grid, then searches: each cell taken from the work queue passes a
// pop, a take and a calc step, then a neighbor-read step for each of the eight
// neighbor positions and a check step for each neighbor admitted by the grid
// rule. Each step makes at most one read and one write of the distance memory.
// Unit-step runs take each reached cell once; weighted runs may take a cell
// again when its distance improves.
`include "grid_distance_map_defines.svh"

module grid_distance_map #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [4:0]  in_row_index,
  input  logic [6:0]  in_col_index,
  input  logic [7:0]  in_hardness,
  output logic        out_valid,
  output logic [19:0] out_distance,
  output logic        out_reached,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int QW    = RW + CW;
  localparam int ENT_W = gdm_pkg::DIST_W + 1;
  localparam int LW    = gdm_pkg::LIM_W;
  localparam int DW    = gdm_pkg::DIST_W;

  // Memories: distance entry is {queued, distance}
  logic [ENT_W-1:0]          dist_mem  [CELLS];
  logic [gdm_pkg::HARD_W-1:0] hard_mem [CELLS];
  logic [QW-1:0]             queue_mem [CELLS];

  logic [ENT_W-1:0]           cell_rd_r;
  logic [gdm_pkg::HARD_W-1:0] hard_rd_r;
  logic [QW-1:0]              q_rd_r;

  gdm_pkg::state_t state_r, state_nxt;
  logic [5:0]      rows_used_r;
  logic [7:0]      cols_used_r;
  logic            tunneling_r;
  logic            ran_r, ran_nxt;
  logic            src_ok_r, src_ok_nxt;
  logic [RW-1:0]   cur_y_r, cur_y_nxt;
  logic [CW-1:0]   cur_x_r, cur_x_nxt;
  logic [DW-1:0]   alt_r, alt_nxt;
  logic [2:0]      nb_r, nb_nxt;
  logic [AW-1:0]   clr_ptr_r, clr_ptr_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0] q_count_r, q_count_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            q_ok_r, q_ok_nxt;

  logic            accept;
  logic            in_inside;
  logic [AW-1:0]   in_addr;
  logic [LW-1:0]   nr, nc;
  logic [LW-1:0]   ny, nx;
  logic            nb_in_grid, nb_open, nb_ok;
  logic [AW-1:0]   nb_addr, cur_addr, head_addr, cell_raddr;
  logic [DW:0]     alt_sum;
  logic [gdm_pkg::HARD_W-1:0] step;
  logic            improve;
  logic            cfg_wr;

  logic             dist_we;
  logic [AW-1:0]    dist_waddr;
  logic [ENT_W-1:0] dist_wdata;
  logic             queue_we;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(CELLS - 1)) ? '0 : p + AW'(1);
  endfunction

  // Grid limits, clamped to storage
  assign nr = (LW'(rows_used_r) > LW'(MAX_ROWS)) ? LW'(MAX_ROWS) : LW'(rows_used_r);
  assign nc = (LW'(cols_used_r) > LW'(MAX_COLS)) ? LW'(MAX_COLS) : LW'(cols_used_r);

  assign busy   = (state_r != gdm_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign in_inside = (LW'(in_row_index) < LW'(MAX_ROWS)) &&
                     (LW'(in_col_index) < LW'(MAX_COLS));
  assign in_addr   = AW'(int'(in_row_index) * MAX_COLS + int'(in_col_index));

  // Neighbor position and its admission rule
  assign ny = LW'(cur_y_r) + gdm_pkg::nb_dy(nb_r);
  assign nx = LW'(cur_x_r) + gdm_pkg::nb_dx(nb_r);
  assign nb_in_grid = (ny != '0) && (nx != '0) && (ny < nr) && (nx < nc);
  assign nb_open    = nb_in_grid && ((ny + LW'(1)) < nr) && ((nx + LW'(1)) < nc);
  assign nb_ok      = tunneling_r ? nb_in_grid : nb_open;
  assign nb_addr    = AW'(int'(ny) * MAX_COLS + int'(nx));
  assign cur_addr   = AW'(int'(cur_y_r) * MAX_COLS + int'(cur_x_r));
  assign head_addr  = AW'(int'(q_rd_r[QW-1:CW]) * MAX_COLS + int'(q_rd_r[CW-1:0]));

  // Tentative distance through the current cell
  assign step    = tunneling_r ? gdm_pkg::leave_cost(hard_rd_r) : 8'd1;
  assign alt_sum = (DW+1)'(cell_rd_r[DW-1:0]) + (DW+1)'(step);
  assign improve = (tunneling_r || (hard_rd_r == '0)) && (alt_r < cell_rd_r[DW-1:0]);

  // Read address of the distance and hardness memories
  always_comb begin
    case (state_r)
      gdm_pkg::ST_CUR: cell_raddr = head_addr;
      gdm_pkg::ST_NRD: cell_raddr = nb_addr;
      default:         cell_raddr = in_addr;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    ran_nxt       = ran_r;
    src_ok_nxt    = src_ok_r;
    cur_y_nxt     = cur_y_r;
    cur_x_nxt     = cur_x_r;
    alt_nxt       = alt_r;
    nb_nxt        = nb_r;
    clr_ptr_nxt   = clr_ptr_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    q_count_nxt   = q_count_r;
    out_valid_nxt = 1'b0;
    q_ok_nxt      = q_ok_r;
    dist_we       = 1'b0;
    dist_waddr    = cur_addr;
    dist_wdata    = {1'b0, gdm_pkg::DIST_NONE};
    queue_we      = 1'b0;
    case (state_r)
      gdm_pkg::ST_IDLE: begin
        if (accept && in_mode == gdm_pkg::MODE_QUERY) begin
          out_valid_nxt = 1'b1;
          q_ok_nxt      = in_inside && ran_r;
        end
        if (accept && in_mode == gdm_pkg::MODE_RUN) begin
          ran_nxt     = 1'b1;
          src_ok_nxt  = (LW'(in_row_index) < nr) && (LW'(in_col_index) < nc);
          cur_y_nxt   = RW'(in_row_index);
          cur_x_nxt   = CW'(in_col_index);
          clr_ptr_nxt = '0;
          head_nxt    = '0;
          tail_nxt    = '0;
          q_count_nxt = '0;
          state_nxt   = gdm_pkg::ST_CLEAR;
        end
      end
      gdm_pkg::ST_CLEAR: begin
        dist_we     = 1'b1;
        dist_waddr  = clr_ptr_r;
        clr_ptr_nxt = ptr_inc(clr_ptr_r);
        if (clr_ptr_r == AW'(CELLS - 1)) begin
          state_nxt = src_ok_r ? gdm_pkg::ST_SEED : gdm_pkg::ST_IDLE;
        end
      end
      gdm_pkg::ST_SEED: begin
        // source gets distance 0 and enters the queue
        dist_we     = 1'b1;
        dist_wdata  = {1'b1, DW'(0)};
        queue_we    = 1'b1;
        tail_nxt    = ptr_inc(tail_r);
        q_count_nxt = CNT_W'(1);
        state_nxt   = gdm_pkg::ST_POP;
      end
      gdm_pkg::ST_POP: begin
        state_nxt = (q_count_r == '0) ? gdm_pkg::ST_IDLE : gdm_pkg::ST_CUR;
      end
      gdm_pkg::ST_CUR: begin
        // take the head cell, its entry is read this cycle
        cur_y_nxt   = q_rd_r[QW-1:CW];
        cur_x_nxt   = q_rd_r[CW-1:0];
        head_nxt    = ptr_inc(head_r);
        q_count_nxt = q_count_r - CNT_W'(1);
        state_nxt   = gdm_pkg::ST_CALC;
      end
      gdm_pkg::ST_CALC: begin
        // drop the queued mark, keep the distance
        dist_we    = 1'b1;
        dist_wdata = {1'b0, cell_rd_r[DW-1:0]};
        alt_nxt    = (alt_sum > (DW+1)'(gdm_pkg::DIST_TOP)) ? gdm_pkg::DIST_TOP
                                                             : alt_sum[DW-1:0];
        nb_nxt     = '0;
        state_nxt  = gdm_pkg::ST_NRD;
      end
      gdm_pkg::ST_NRD: begin
        if (nb_ok) begin
          state_nxt = gdm_pkg::ST_NCHK;
        end else if (nb_r == 3'd7) begin
          state_nxt = gdm_pkg::ST_POP;
        end else begin
          nb_nxt = nb_r + 3'd1;
        end
      end
      gdm_pkg::ST_NCHK: begin
        // relax the neighbor, enqueue it if not already waiting
        if (improve) begin
          dist_we    = 1'b1;
          dist_waddr = nb_addr;
          dist_wdata = {1'b1, alt_r};
          if (!cell_rd_r[DW]) begin
            queue_we    = 1'b1;
            tail_nxt    = ptr_inc(tail_r);
            q_count_nxt = q_count_r + CNT_W'(1);
          end
        end
        if (nb_r == 3'd7) begin
          state_nxt = gdm_pkg::ST_POP;
        end else begin
          nb_nxt    = nb_r + 3'd1;
          state_nxt = gdm_pkg::ST_NRD;
        end
      end
      default: state_nxt = gdm_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdm_pkg::ST_IDLE;
      ran_r       <= 1'b0;
      q_count_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ran_r       <= ran_nxt;
      q_count_r   <= q_count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    src_ok_r  <= src_ok_nxt;
    cur_y_r   <= cur_y_nxt;
    cur_x_r   <= cur_x_nxt;
    alt_r     <= alt_nxt;
    nb_r      <= nb_nxt;
    clr_ptr_r <= clr_ptr_nxt;
    q_ok_r    <= q_ok_nxt;
  end

  // Distance memory
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    cell_rd_r <= dist_mem[cell_raddr];
  end

  // Hardness memory
  always_ff @(posedge clk) begin
    if (accept && in_mode == gdm_pkg::MODE_LOAD && in_inside) begin
      hard_mem[in_addr] <= in_hardness;
    end
    hard_rd_r <= hard_mem[cell_raddr];
  end

  // Work queue memory, entries are {row, column}
  always_ff @(posedge clk) begin
    if (queue_we) begin
      queue_mem[tail_r] <= (state_r == gdm_pkg::ST_SEED) ? {cur_y_r, cur_x_r}
                                                          : {ny[RW-1:0], nx[CW-1:0]};
    end
    q_rd_r <= queue_mem[head_r];
  end

  // Result
  assign out_valid    = out_valid_r;
  assign out_distance = q_ok_r ? cell_rd_r[DW-1:0] : gdm_pkg::DIST_NONE;
  assign out_reached  = (out_distance != gdm_pkg::DIST_NONE);

  // APB registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= 6'd21;
      cols_used_r <= 8'd80;
      tunneling_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        gdm_pkg::REG_ROWS_USED: rows_used_r <= pwdata[5:0];
        gdm_pkg::REG_COLS_USED: cols_used_r <= pwdata[7:0];
        gdm_pkg::REG_TUNNELING: tunneling_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gdm_pkg::REG_ROWS_USED: prdata = 32'(rows_used_r);
      gdm_pkg::REG_COLS_USED: prdata = 32'(cols_used_r);
      gdm_pkg::REG_TUNNELING: prdata = 32'(tunneling_r);
      default:                prdata = '0;
    endcase
  end

  // Checks
  `GDM_ASSERT_NOW(a_q_bound, 1'b1, q_count_r <= CNT_W'(CELLS), "work queue over capacity")
  `GDM_ASSERT_NOW(a_pop_nonempty, state_r == gdm_pkg::ST_CUR, q_count_r != '0, "pop of empty queue")
  `GDM_ASSERT_NEXT(a_query_result, accept && in_mode == gdm_pkg::MODE_QUERY, out_valid, "query result missing")

endmodule
